FILE: rtl/ffa_pkg.sv
// Shared types, codes and defaults of the first-fit block allocator.
package ffa_pkg;

	localparam int FIELD_W    = 16;
	localparam int STATUS_W   = 3;
	localparam int MAX_BLOCKS_DEF = 16;
	localparam int ADDR_BITS_DEF  = 16;
	localparam logic [FIELD_W-1:0] BASE_RESET = 16'd1000;

	// Request commands
	localparam logic CMD_CLAIM = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Config register indexes
	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_POOL = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NO_SPACE  = 3'd1;
	localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] STS_ZERO      = 3'd4;

	typedef struct packed {
		logic               command;
		logic [FIELD_W-1:0] request_size;
		logic [FIELD_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  granted_address;
		logic [FIELD_W-1:0]  freed_size;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEG_RD,
		ST_SEG_CHK,
		ST_ALC_RD,
		ST_ALC_CHK,
		ST_MERGE,
		ST_SH_RD,
		ST_SH_WR,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/ffa_seq.sv
// Table sequencer: free-segment and allocation RAMs with the request state machine.
module ffa_seq #(
	parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = ffa_pkg::ADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         init_we,
	input  logic [ADDR_BITS-1:0]         init_addr,
	input  logic [ffa_pkg::FIELD_W-1:0]  init_len,
	input  logic                         start,
	input  ffa_pkg::req_t                req,
	input  logic                         take,
	output logic                         busy,
	output logic                         done,
	output ffa_pkg::rsp_t                res
);

	localparam int LW   = ffa_pkg::FIELD_W;
	localparam int FD   = MAX_BLOCKS + 1;
	localparam int FIW  = $clog2(FD);
	localparam int CNTW = $clog2(FD + 1);
	localparam int AIW  = $clog2(MAX_BLOCKS);
	localparam int SLW  = AIW + 1;
	localparam int EW   = ADDR_BITS + 1;
	localparam int RW   = ADDR_BITS + LW;

	ffa_pkg::state_t state_q, state_d;

	logic                 cmd_q;
	logic [LW-1:0]        size_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [CNTW-1:0]      idx_q, pos_q, cnt_q;
	logic [SLW-1:0]       j_q;
	logic [AIW-1:0]       slot_q;
	logic [LW-1:0]        len_q;
	logic [ADDR_BITS-1:0] prev_a_q, next_a_q;
	logic [LW-1:0]        prev_l_q, next_l_q;
	logic                 has_next_q, down_q;
	logic [MAX_BLOCKS-1:0] valid_q;
	ffa_pkg::rsp_t        res_q;

	// RAM ports
	logic                 fr_we;
	logic [FIW-1:0]       fr_waddr, fr_raddr;
	logic [RW-1:0]        fr_wdata, fr_rdata;
	logic                 al_we;
	logic [AIW-1:0]       al_waddr, al_raddr;
	logic [RW-1:0]        al_wdata, al_rdata;

	ffa_ram #(.WIDTH(RW), .DEPTH(FD)) u_free_ram (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fr_rdata)
	);

	ffa_ram #(.WIDTH(RW), .DEPTH(MAX_BLOCKS)) u_alloc_ram (
		.clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
		.raddr(al_raddr), .rdata(al_rdata)
	);

	logic [ADDR_BITS-1:0] rd_a, al_a;
	logic [LW-1:0]        rd_l, al_l;
	assign rd_a = fr_rdata[RW-1 -: ADDR_BITS];
	assign rd_l = fr_rdata[LW-1:0];
	assign al_a = al_rdata[RW-1 -: ADDR_BITS];
	assign al_l = al_rdata[LW-1:0];

	// First unused allocation slot
	logic           have_slot;
	logic [AIW-1:0] free_slot;
	always_comb begin
		have_slot = 1'b0;
		free_slot = '0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				have_slot = 1'b1;
				free_slot = AIW'(i);
			end
		end
	end

	// Scan and merge conditions
	logic is_claim, scan_end, fit, exact, at_pos, al_hit, al_end;
	logic has_prev, wp, wn, tbl_full, sh_more;
	logic [CNTW-1:0] sh_src, pos_m1;
	assign is_claim = cmd_q == ffa_pkg::CMD_CLAIM;
	assign scan_end = idx_q >= cnt_q;
	assign fit      = rd_l >= size_q;
	assign exact    = rd_l == size_q;
	assign at_pos   = rd_a >= addr_q;
	assign al_hit   = valid_q[j_q[AIW-1:0]] && (al_a == addr_q);
	assign al_end   = j_q == SLW'(MAX_BLOCKS);
	assign has_prev = idx_q != '0;
	assign pos_m1   = idx_q - CNTW'(1);
	assign wp = has_prev &&
		(({1'b0, prev_a_q} + EW'(prev_l_q)) == {1'b0, addr_q});
	assign wn = has_next_q &&
		(({1'b0, addr_q} + EW'(len_q)) == {1'b0, next_a_q});
	assign tbl_full = !wp && !wn && (cnt_q >= CNTW'(FD));
	assign sh_src   = down_q ? idx_q + CNTW'(1) : idx_q - CNTW'(1);
	assign sh_more  = down_q ? ((idx_q + CNTW'(1)) < cnt_q) : (idx_q > pos_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM controls
	always_comb begin
		state_d  = state_q;
		fr_we    = 1'b0;
		fr_waddr = idx_q[FIW-1:0];
		fr_wdata = {addr_q, len_q};
		fr_raddr = idx_q[FIW-1:0];
		al_we    = 1'b0;
		al_waddr = free_slot;
		al_wdata = {rd_a, size_q};
		al_raddr = j_q[AIW-1:0];
		case (state_q)
			ffa_pkg::ST_IDLE: begin
				if (init_we) begin
					fr_we    = 1'b1;
					fr_waddr = '0;
					fr_wdata = {init_addr, init_len};
				end else if (start) begin
					if (req.command == ffa_pkg::CMD_FREE) begin
						state_d = ffa_pkg::ST_ALC_RD;
					end else if (req.request_size == '0) begin
						state_d = ffa_pkg::ST_DONE;
					end else begin
						state_d = ffa_pkg::ST_SEG_RD;
					end
				end
			end
			ffa_pkg::ST_SEG_RD: begin
				if (!scan_end) begin
					state_d = ffa_pkg::ST_SEG_CHK;
				end else if (is_claim) begin
					state_d = ffa_pkg::ST_DONE;
				end else begin
					state_d = ffa_pkg::ST_MERGE;
				end
			end
			ffa_pkg::ST_SEG_CHK: begin
				if (is_claim) begin
					if (!fit) begin
						state_d = ffa_pkg::ST_SEG_RD;
					end else if (!have_slot) begin
						state_d = ffa_pkg::ST_DONE;
					end else begin
						al_we = 1'b1;
						if (exact) begin
							state_d = ffa_pkg::ST_SH_RD;
						end else begin
							fr_we    = 1'b1;
							fr_wdata = {rd_a + ADDR_BITS'(size_q), rd_l - size_q};
							state_d  = ffa_pkg::ST_DONE;
						end
					end
				end else begin
					state_d = at_pos ? ffa_pkg::ST_MERGE : ffa_pkg::ST_SEG_RD;
				end
			end
			ffa_pkg::ST_ALC_RD: begin
				state_d = al_end ? ffa_pkg::ST_DONE : ffa_pkg::ST_ALC_CHK;
			end
			ffa_pkg::ST_ALC_CHK: begin
				state_d = al_hit ? ffa_pkg::ST_SEG_RD : ffa_pkg::ST_ALC_RD;
			end
			ffa_pkg::ST_MERGE: begin
				if (tbl_full) begin
					state_d = ffa_pkg::ST_DONE;
				end else if (wp && wn) begin
					fr_we    = 1'b1;
					fr_waddr = pos_m1[FIW-1:0];
					fr_wdata = {prev_a_q, prev_l_q + len_q + next_l_q};
					state_d  = ffa_pkg::ST_SH_RD;
				end else if (wp) begin
					fr_we    = 1'b1;
					fr_waddr = pos_m1[FIW-1:0];
					fr_wdata = {prev_a_q, prev_l_q + len_q};
					state_d  = ffa_pkg::ST_DONE;
				end else if (wn) begin
					fr_we    = 1'b1;
					fr_wdata = {addr_q, next_l_q + len_q};
					state_d  = ffa_pkg::ST_DONE;
				end else begin
					state_d = ffa_pkg::ST_SH_RD;
				end
			end
			ffa_pkg::ST_SH_RD: begin
				fr_raddr = sh_src[FIW-1:0];
				if (sh_more) begin
					state_d = ffa_pkg::ST_SH_WR;
				end else begin
					// upward shift ends by placing the freed block at its slot
					if (!down_q) begin
						fr_we    = 1'b1;
						fr_waddr = pos_q[FIW-1:0];
					end
					state_d = ffa_pkg::ST_DONE;
				end
			end
			ffa_pkg::ST_SH_WR: begin
				fr_we    = 1'b1;
				fr_wdata = fr_rdata;
				state_d  = ffa_pkg::ST_SH_RD;
			end
			ffa_pkg::ST_DONE: begin
				if (take) begin
					state_d = ffa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffa_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers: segment count and allocation valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= '0;
		end else begin
			case (state_q)
				ffa_pkg::ST_IDLE: begin
					if (init_we) begin
						cnt_q   <= CNTW'(init_len != '0);
						valid_q <= '0;
					end
				end
				ffa_pkg::ST_SEG_CHK: begin
					if (is_claim && fit && have_slot) begin
						valid_q[free_slot] <= 1'b1;
					end
				end
				ffa_pkg::ST_MERGE: begin
					if (!tbl_full) begin
						valid_q[slot_q] <= 1'b0;
					end
				end
				ffa_pkg::ST_SH_RD: begin
					if (!sh_more) begin
						cnt_q <= down_q ? cnt_q - CNTW'(1) : cnt_q + CNTW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the request in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ffa_pkg::ST_IDLE: begin
				cmd_q  <= req.command;
				size_q <= req.request_size;
				addr_q <= ADDR_BITS'(req.block_address);
				idx_q  <= '0;
				j_q    <= '0;
				has_next_q <= 1'b0;
				res_q  <= '{status: (req.command == ffa_pkg::CMD_CLAIM &&
					req.request_size == '0) ? ffa_pkg::STS_ZERO : ffa_pkg::STS_OK,
					granted_address: '0, freed_size: '0};
			end
			ffa_pkg::ST_SEG_RD: begin
				if (scan_end) begin
					if (is_claim) begin
						res_q.status <= ffa_pkg::STS_NO_SPACE;
					end
				end
			end
			ffa_pkg::ST_SEG_CHK: begin
				if (is_claim) begin
					if (!fit) begin
						idx_q <= idx_q + CNTW'(1);
					end else if (!have_slot) begin
						res_q.status <= ffa_pkg::STS_FULL;
					end else begin
						res_q.granted_address <= ffa_pkg::FIELD_W'(rd_a);
						down_q <= 1'b1;
					end
				end else if (at_pos) begin
					next_a_q   <= rd_a;
					next_l_q   <= rd_l;
					has_next_q <= 1'b1;
				end else begin
					prev_a_q <= rd_a;
					prev_l_q <= rd_l;
					idx_q    <= idx_q + CNTW'(1);
				end
			end
			ffa_pkg::ST_ALC_RD: begin
				if (al_end) begin
					res_q.status <= ffa_pkg::STS_NOT_ALLOC;
				end
			end
			ffa_pkg::ST_ALC_CHK: begin
				if (al_hit) begin
					len_q  <= al_l;
					slot_q <= j_q[AIW-1:0];
					idx_q  <= '0;
				end else begin
					j_q <= j_q + SLW'(1);
				end
			end
			ffa_pkg::ST_MERGE: begin
				pos_q <= idx_q;
				if (tbl_full) begin
					res_q.status <= ffa_pkg::STS_FULL;
				end else begin
					res_q.freed_size <= len_q;
					down_q <= wp && wn;
					if (!wp && !wn) begin
						idx_q <= cnt_q;
					end
				end
			end
			ffa_pkg::ST_SH_WR: begin
				idx_q <= down_q ? idx_q + CNTW'(1) : idx_q - CNTW'(1);
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != ffa_pkg::ST_IDLE;
	assign done = state_q == ffa_pkg::ST_DONE;
	assign res  = res_q;

endmodule

FILE: rtl/first_fit_block_allocator.sv
// A claim scans the free segments in order and, when a segment empties, shifts the
// entries behind it down; a free scans the allocation slots, then the free segments,
// then merges with its neighbours (shifting entries down when both join) or shifts
// entries up to insert a new segment; the result then goes into the output register.
// One request at a time, paced by the single read port of the free-segment RAM.
// Reset: base 1000, empty pool, no allocations; no clearing pass, ready at once.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = ffa_pkg::ADDR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [ffa_pkg::FIELD_W-1:0] cfg_data,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  ffa_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output ffa_pkg::rsp_t               rsp
);

	localparam int LW = ffa_pkg::FIELD_W;
	localparam int CW = ((ADDR_BITS > LW) ? ADDR_BITS : LW) + 1;

	logic [LW-1:0] base_q, pool_q, base_d, pool_d;

	// Config registers; a write while the sequencer is idle reinitializes the pool
	always_comb begin
		base_d = base_q;
		pool_d = pool_q;
		if (cfg_we) begin
			if (cfg_index == ffa_pkg::CFG_BASE) begin
				base_d = cfg_data;
			end else begin
				pool_d = cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ffa_pkg::BASE_RESET;
			pool_q <= '0;
		end else begin
			base_q <= base_d;
			pool_q <= pool_d;
		end
	end

	// Usable length: pool cut to the room below the top of the address space
	logic [ADDR_BITS-1:0] init_addr;
	logic [CW-1:0]        room, pool_x;
	logic [LW-1:0]        init_len;
	assign init_addr = ADDR_BITS'(base_d);
	assign room      = (CW'(1) << ADDR_BITS) - CW'(init_addr);
	assign pool_x    = CW'(pool_d);
	assign init_len  = (pool_x < room) ? pool_d : LW'(room);

	logic          busy, done, take;
	ffa_pkg::rsp_t res;

	ffa_seq #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.init_we(cfg_we), .init_addr(init_addr), .init_len(init_len),
		.start(req_valid), .req(req), .take(take),
		.busy(busy), .done(done), .res(res)
	);

	assign req_stall = busy;

	// Output register
	logic          rsp_valid_q;
	ffa_pkg::rsp_t rsp_q;
	assign take = done && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sim/ffa_checker.sv
// Checker for the first-fit allocator: shadow pool model and in-order result compare.
module ffa_checker
	import ffa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rsp_t                 rsp,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBLK = MAX_BLOCKS_DEF;
	localparam int NSEG = NBLK + 1;
	localparam int SPACE = 1 << ADDR_BITS_DEF;

	// shadow pool state, kept wide to avoid wrap
	int unsigned pool_base, pool_bytes;
	int unsigned seg_addr [NSEG];
	int unsigned seg_len  [NSEG];
	int unsigned seg_cnt;
	int unsigned blk_addr [NBLK];
	int unsigned blk_len  [NBLK];
	bit          blk_used [NBLK];

	rsp_t expected_rsps [$];

	function automatic void rebuild_pool();
		int unsigned room, len;
		room = SPACE - pool_base;
		len = (pool_bytes < room) ? pool_bytes : room;
		for (int i = 0; i < NSEG; i++) begin
			seg_addr[i] = 0;
			seg_len[i] = 0;
		end
		for (int i = 0; i < NBLK; i++) begin
			blk_used[i] = 0;
			blk_addr[i] = 0;
			blk_len[i] = 0;
		end
		seg_addr[0] = pool_base;
		seg_len[0] = len;
		seg_cnt = (len != 0) ? 1 : 0;
	endfunction

	// drop free segment k, shifting the tail down
	function automatic void drop_segment(int unsigned k);
		for (int unsigned i = k; i + 1 < seg_cnt; i++) begin
			seg_addr[i] = seg_addr[i+1];
			seg_len[i] = seg_len[i+1];
		end
		seg_cnt--;
		seg_addr[seg_cnt] = 0;
		seg_len[seg_cnt] = 0;
	endfunction

	function automatic rsp_t claim_block(int unsigned size);
		rsp_t r;
		int unsigned s, b;
		r = '0;
		if (size == 0) begin
			r.status = STS_ZERO;
			return r;
		end
		for (s = 0; s < seg_cnt; s++)
			if (seg_len[s] >= size) break;
		if (s >= seg_cnt) begin
			r.status = STS_NO_SPACE;
			return r;
		end
		for (b = 0; b < NBLK; b++)
			if (!blk_used[b]) break;
		if (b >= NBLK) begin
			r.status = STS_FULL;
			return r;
		end
		r.status = STS_OK;
		r.granted_address = seg_addr[s][FIELD_W-1:0];
		blk_addr[b] = seg_addr[s];
		blk_len[b] = size;
		blk_used[b] = 1;
		seg_addr[s] += size;
		seg_len[s] -= size;
		if (seg_len[s] == 0) drop_segment(s);
		return r;
	endfunction

	function automatic rsp_t release_block(int unsigned addr);
		rsp_t r;
		int unsigned b, p, len;
		bit join_lo, join_hi;
		r = '0;
		for (b = 0; b < NBLK; b++)
			if (blk_used[b] && blk_addr[b] == addr) break;
		if (b >= NBLK) begin
			r.status = STS_NOT_ALLOC;
			return r;
		end
		len = blk_len[b];
		for (p = 0; p < seg_cnt; p++)
			if (seg_addr[p] >= addr) break;
		join_lo = p > 0 && seg_addr[p-1] + seg_len[p-1] == addr;
		join_hi = p < seg_cnt && addr + len == seg_addr[p];
		if (!join_lo && !join_hi && seg_cnt >= NSEG) begin
			r.status = STS_FULL;
			return r;
		end
		if (join_lo && join_hi) begin
			seg_len[p-1] += len + seg_len[p];
			drop_segment(p);
		end else if (join_lo) begin
			seg_len[p-1] += len;
		end else if (join_hi) begin
			seg_addr[p] = addr;
			seg_len[p] += len;
		end else begin
			for (int unsigned i = seg_cnt; i > p; i--) begin
				seg_addr[i] = seg_addr[i-1];
				seg_len[i] = seg_len[i-1];
			end
			seg_addr[p] = addr;
			seg_len[p] = len;
			seg_cnt++;
		end
		blk_used[b] = 0;
		r.status = STS_OK;
		r.freed_size = len[FIELD_W-1:0];
		return r;
	endfunction

	assign pending = expected_rsps.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			pool_base = BASE_RESET;
			pool_bytes = 0;
			rebuild_pool();
			expected_rsps.delete();
			fail_count = 0;
		end else begin
			// config writes reinitialize the pool
			if (cfg_we) begin
				if (cfg_index == CFG_BASE) pool_base = cfg_data;
				else pool_bytes = cfg_data;
				rebuild_pool();
			end
			// predict each accepted request
			if (req_valid && !req_stall) begin
				if (req.command == CMD_CLAIM)
					expected_rsps.push_back(claim_block(req.request_size));
				else
					expected_rsps.push_back(release_block(req.block_address));
			end
			// compare each accepted result
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected result %p", rsp);
					fail_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status) begin
						$error("status exp %0d got %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.granted_address !== want.granted_address) begin
						$error("granted_address exp %0d got %0d",
							want.granted_address, rsp.granted_address);
						fail_count++;
					end
					if (rsp.freed_size !== want.freed_size) begin
						$error("freed_size exp %0d got %0d",
							want.freed_size, rsp.freed_size);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

FILE: sim/first_fit_block_allocator_tb.sv
// Testbench top for the first-fit allocator: stimulus, config phases and verdict.
module first_fit_block_allocator_tb;
	import ffa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 6 * MAX_BLOCKS_DEF + 20;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = CFG_BASE;
	logic [FIELD_W-1:0] cfg_data = '0;
	logic req_valid = 0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	rsp_t rsp;
	int fail_count, pending;
	int idle_cycles = 0;

	// addresses granted and still held, for well-formed frees
	logic [FIELD_W-1:0] held [$];

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	first_fit_block_allocator DUT (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
	);

	ffa_checker u_chk (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
		.fail_count, .pending
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// track held addresses from accepted results
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall && rsp.status == STS_OK && rsp.granted_address != 0)
			held.push_back(rsp.granted_address);
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver back-pressure
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = gap_len();
			@(negedge clk) rsp_stall <= (n != 0);
			repeat (n) @(negedge clk);
			@(negedge clk) rsp_stall <= 0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	// valid stays up after acceptance until the next call decides gap or new request
	task automatic send(input logic cmd, input logic [FIELD_W-1:0] size,
			input logic [FIELD_W-1:0] addr);
		int n;
		n = gap_len();
		if (n != 0) begin
			req_valid <= 0;
			repeat (n) @(negedge clk);
		end
		req_valid <= 1;
		req <= '{command: cmd, request_size: size, block_address: addr};
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [FIELD_W-1:0] val);
		// drain, then let the block settle before touching config
		req_valid <= 0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		held.delete();
	endtask

	task automatic random_phase(input int count);
		int r, k;
		logic [FIELD_W-1:0] a;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				// mostly small claims, some huge
				if ($urandom_range(0, 9) == 0)
					send(CMD_CLAIM, FIELD_W'($urandom), FIELD_W'($urandom));
				else
					send(CMD_CLAIM, FIELD_W'($urandom_range(1, 64)), FIELD_W'($urandom));
			end else if (r < 85 && held.size() > 0) begin
				k = $urandom_range(0, held.size() - 1);
				a = held[k];
				held.delete(k);
				send(CMD_FREE, FIELD_W'($urandom), a);
			end else if (r < 92) begin
				send(CMD_CLAIM, 0, FIELD_W'($urandom));
			end else begin
				send(CMD_FREE, FIELD_W'($urandom), FIELD_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1;
		// empty pool at reset
		send(CMD_CLAIM, 1, 0);
		send(CMD_FREE, 0, BASE_RESET);
		write_reg(CFG_POOL, 16'd200);
		send(CMD_CLAIM, 0, 0);
		send(CMD_CLAIM, 16'hFFFF, 16'hFFFF);
		send(CMD_CLAIM, 50, 0);
		send(CMD_CLAIM, 50, 0);
		send(CMD_CLAIM, 100, 0);
		send(CMD_CLAIM, 1, 0);
		send(CMD_FREE, 0, 1050);
		send(CMD_FREE, 0, 1050);
		send(CMD_FREE, 0, 1000);
		send(CMD_FREE, 0, 1100);
		// fill the allocation table
		write_reg(CFG_BASE, 16'd0);
		for (int i = 0; i < 17; i++) send(CMD_CLAIM, 1, 0);
		send(CMD_FREE, 0, 16'd3);
		send(CMD_FREE, 0, 16'd5);
		send(CMD_FREE, 0, 16'd4);
		// pool clipped at top of address space
		write_reg(CFG_BASE, 16'hFFF0);
		write_reg(CFG_POOL, 16'hFFFF);
		send(CMD_CLAIM, 17, 0);
		send(CMD_CLAIM, 16, 0);
		send(CMD_FREE, 0, 16'hFFF0);
		random_phase(100);
		write_reg(CFG_BASE, 16'd0);
		random_phase(100);
		write_reg(CFG_POOL, 16'd300);
		write_reg(CFG_BASE, FIELD_W'($urandom));
		random_phase(150);
		write_reg(CFG_BASE, 16'h8000);
		write_reg(CFG_POOL, 16'd0);
		random_phase(10);
		write_reg(CFG_POOL, 16'h7FFF);
		random_phase(150);
		req_valid <= 0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

FILE: sim.f
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_seq.sv
rtl/first_fit_block_allocator.sv
sim/ffa_checker.sv
sim/first_fit_block_allocator_tb.sv
